// ----- src/sca_pkg.sv -----
// Shared types, scan codes and key tables for the scan code to ASCII queue.
// No dependencies; imported by sca_fifo and scancode_to_ascii_fifo.
package sca_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int TABLE_LEN       = 84;
   localparam logic [7:0] NO_CHAR = 8'h80;

   // Request kind carried in tuser
   typedef enum logic {
      OP_SCAN = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   // Set-1 modifier and prefix codes
   localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
   localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
   localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
   localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
   localparam logic [7:0] SC_CTRL_MAKE    = 8'h1D;
   localparam logic [7:0] SC_CTRL_BREAK   = 8'h9D;
   localparam logic [7:0] SC_ALT_MAKE     = 8'h38;
   localparam logic [7:0] SC_ALT_BREAK    = 8'hB8;
   localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;
   localparam logic [7:0] SC_CAPS_BREAK   = 8'hBA;
   localparam logic [7:0] SC_EXT_PREFIX   = 8'hE0;

   typedef struct packed {
      logic full;
      logic empty;
      logic empty_next;
   } fifo_stat_type;

   localparam logic [7:0] TAB_PLAIN [TABLE_LEN] = '{
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h0D, 8'h09,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h80,
      8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
      8'h6C, 8'h3B, 8'h2F, 8'h8C, 8'h80, 8'h86,
      8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C,
      8'h2E, 8'h2F, 8'h80, 8'h2A, 8'h80, 8'h20,
      8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
      8'h80, 8'h80, 8'h80, 8'h80,
      8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
      8'h80, 8'h80, 8'h80, 8'h80,
      8'h30, 8'hB1
   };

   localparam logic [7:0] TAB_SHIFT [TABLE_LEN] = '{
      8'h00, 8'h21, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
      8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h0D, 8'h09,
      8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0F, 8'h80,
      8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
      8'h4C, 8'h3A, 8'h2A, 8'h7E, 8'h80, 8'h7C,
      8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h3C,
      8'h3E, 8'h3F, 8'h80, 8'h2A, 8'h80, 8'h20,
      8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
      8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
      8'h37, 8'h38, 8'h39, 8'h80, 8'h34, 8'h35, 8'h36, 8'h80,
      8'h31, 8'h32, 8'h33, 8'h30, 8'hB1
   };

   localparam logic [7:0] TAB_CAPS [TABLE_LEN] = '{
      8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h0D, 8'h09,
      8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h5B, 8'h5D, 8'h0A, 8'h80,
      8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
      8'h4C, 8'h3B, 8'h2F, 8'h8C, 8'h80, 8'h7C,
      8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h2C,
      8'h2E, 8'h2F, 8'h80, 8'h2A, 8'h80, 8'h20,
      8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
      8'h80, 8'h80, 8'h80, 8'h80,
      8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
      8'h80, 8'h80, 8'h80, 8'h80,
      8'h30, 8'hB1
   };

   localparam logic [7:0] TAB_CAPS_SHIFT [TABLE_LEN] = '{
      8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
      8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h0D, 8'h09,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h7B, 8'h7D, 8'h0D, 8'h80,
      8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
      8'h6C, 8'h3A, 8'h2A, 8'h7E, 8'h80, 8'h86,
      8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h3C,
      8'h3E, 8'h3F, 8'h80, 8'h2A, 8'h80, 8'h20,
      8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
      8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
      8'h37, 8'h38, 8'h39, 8'h80, 8'h34, 8'h35, 8'h36, 8'h80,
      8'h31, 8'h32, 8'h33, 8'h30, 8'hB1
   };

   // Make code to character; codes past the table end give NO_CHAR
   function automatic logic [7:0] key_lookup(input logic shift, input logic caps,
                                             input logic [6:0] code);
      logic [7:0] ch;
      if (code >= 7'(TABLE_LEN)) begin
         ch = NO_CHAR;
      end else if (shift) begin
         ch = caps ? TAB_CAPS_SHIFT[code] : TAB_SHIFT[code];
      end else begin
         ch = caps ? TAB_CAPS[code] : TAB_PLAIN[code];
      end
      return ch;
   endfunction

endpackage

// ----- src/sca_fifo.sv -----
// Character queue: storage array, read/write pointers and fill count.
// Depends on sca_pkg for the status struct.
module sca_fifo
   import sca_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,       // qualified: not full
   input  logic          pop,        // qualified: not empty
   input  logic [7:0]    push_data,
   output logic [7:0]    pop_data,   // registered, updates on pop
   output fifo_stat_type stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [7:0]       store [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       pop_data_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end else if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store[wr_ptr_ff] <= push_data;
      end
   end

   // A pop never meets a same-cycle write to its entry: the queue is not empty
   always_ff @(posedge clock) begin
      if (pop) begin
         pop_data_ff <= store[rd_ptr_ff];
      end
   end

   assign pop_data        = pop_data_ff;
   assign stat.full       = (count_ff == CNT_W'(DEPTH));
   assign stat.empty      = (count_ff == '0);
   assign stat.empty_next = (count_in == '0);

endmodule

// ----- src/scancode_to_ascii_fifo.sv -----
// Top level: set-1 scan code decoder with modifier tracking and character queue.
// Depends on sca_pkg and sca_fifo.
//
//   channel | dir | tdata                       | tuser
//   --------+-----+-----------------------------+-----------------
//   req_    | in  | scan_code                   | op (0 scan, 1 pop)
//   rsp_    | out | char, flags, modifier state | char_valid
//
// One request per cycle sustained while rsp_tready is high; each result passes
// through the input register, then the result register. The loops are the
// modifier flags and the queue pointer/count update.
// Reset clears the modifiers, pointers and valids; the queue storage is not cleared.
// rsp_tready low holds the result; one further request is still taken into
// the input register before req_tready drops.
module scancode_to_ascii_fifo
   import sca_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] scan_code
   input  logic        req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] char_out, [8] queue_empty, [9] overflow, [10] underflow,
   // [11] shift_state, [12] ctrl_state, [13] alt_state, [14] caps_state, [15] zero
   output logic [15:0] rsp_tdata,
   output logic        rsp_tuser    // [0] char_valid
);

   // input register
   logic       in_vld_ff;
   op_type     in_op_ff;
   logic [7:0] in_code_ff;

   // modifier state
   logic shift_ff, shift_in;
   logic ctrl_ff, ctrl_in;
   logic alt_ff, alt_in;
   logic caps_ff, caps_in;
   logic rearm_ff, rearm_in;

   // result register
   logic rsp_vld_ff;
   logic char_vld_ff, empty_ff, ovf_ff, unf_ff;
   logic r_shift_ff, r_ctrl_ff, r_alt_ff, r_caps_ff;

   logic          advance;
   logic          consumed;
   logic          want_push, want_pop;
   logic          do_push, do_pop;
   logic [7:0]    push_char;
   logic [7:0]    pop_data;
   fifo_stat_type fstat;

   assign advance    = in_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff   <= op_type'(req_tuser);
         in_code_ff <= req_tdata;
      end
   end

   always_comb begin
      shift_in = shift_ff;
      ctrl_in  = ctrl_ff;
      alt_in   = alt_ff;
      caps_in  = caps_ff;
      rearm_in = rearm_ff;
      consumed = 1'b1;
      if (in_op_ff == OP_SCAN) begin
         unique case (in_code_ff)
            SC_RSHIFT_MAKE, SC_LSHIFT_MAKE:   shift_in = 1'b1;
            SC_RSHIFT_BREAK, SC_LSHIFT_BREAK: shift_in = 1'b0;
            SC_CTRL_MAKE:                     ctrl_in  = 1'b1;
            SC_CTRL_BREAK:                    ctrl_in  = 1'b0;
            SC_ALT_MAKE:                      alt_in   = 1'b1;
            SC_ALT_BREAK:                     alt_in   = 1'b0;
            SC_CAPS_MAKE: begin
               // toggle only once per press/release cycle
               if (rearm_ff) begin
                  caps_in  = !caps_ff;
                  rearm_in = 1'b0;
               end
            end
            SC_CAPS_BREAK:                    rearm_in = 1'b1;
            SC_EXT_PREFIX:                    ;
            default:                          consumed = 1'b0;
         endcase
      end
   end

   assign want_push = (in_op_ff == OP_SCAN) && !consumed && !in_code_ff[7];
   assign want_pop  = (in_op_ff == OP_POP);
   assign do_push   = advance && want_push && !fstat.full;
   assign do_pop    = advance && want_pop && !fstat.empty;
   assign push_char = key_lookup(shift_ff, caps_ff, in_code_ff[6:0]);

   sca_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (do_push),
      .pop       (do_pop),
      .push_data (push_char),
      .pop_data  (pop_data),
      .stat      (fstat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
         ctrl_ff  <= 1'b0;
         alt_ff   <= 1'b0;
         caps_ff  <= 1'b0;
         rearm_ff <= 1'b1;
      end else if (advance) begin
         shift_ff <= shift_in;
         ctrl_ff  <= ctrl_in;
         alt_ff   <= alt_in;
         caps_ff  <= caps_in;
         rearm_ff <= rearm_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         char_vld_ff <= do_pop;
         empty_ff    <= fstat.empty_next;
         ovf_ff      <= want_push && fstat.full;
         unf_ff      <= want_pop && fstat.empty;
         r_shift_ff  <= shift_in;
         r_ctrl_ff   <= ctrl_in;
         r_alt_ff    <= alt_in;
         r_caps_ff   <= caps_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = char_vld_ff;
   assign rsp_tdata  = {1'b0, r_caps_ff, r_alt_ff, r_ctrl_ff, r_shift_ff,
                        unf_ff, ovf_ff, empty_ff,
                        (char_vld_ff ? pop_data : 8'h00)};

endmodule
